>>> sv/kruskal_mst_edge_selector_unit_defines.svh
// assertion macros used by the edge selector sequencer
`ifndef KRUSKAL_MST_EDGE_SELECTOR_UNIT_DEFINES_SVH
`define KRUSKAL_MST_EDGE_SELECTOR_UNIT_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, checked while out of reset
`define KMST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked while out of reset
`define KMST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KMST_ASSERT_NOW(label, ante, cons, msg)
`define KMST_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> sv/kmst_pkg.sv
// shared types and constants of the kruskal edge selector
`timescale 1ns / 1ps
package kmst_pkg;

  localparam int VW = 10;
  localparam int TW = 48;

  localparam logic [TW-1:0] TOTAL_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [TW-1:0] TOTAL_MIN = 48'h8000_0000_0000;
  localparam logic [3:0]    RANK_MAX  = 4'hF;
  localparam logic [3:0]    EPOCH_MAX = 4'hF;

  // one forest entry: epoch tag, rank, parent (0 means root)
  typedef struct packed {
    logic [3:0]    tag;
    logic [3:0]    rank;
    logic [VW-1:0] parent;
  } node_t;

  // memory request from the sequencer
  typedef struct packed {
    logic          we;
    logic [VW-1:0] waddr;
    node_t         wdata;
    logic [VW-1:0] raddr;
  } mem_req_t;

  // command from the stream side to the sequencer
  typedef struct packed {
    logic                 start;
    logic [VW-1:0]        vertex_a;
    logic [VW-1:0]        vertex_b;
    logic signed [31:0]   edge_cost;
    logic                 first_edge;
    logic                 out_free;
  } seq_cmd_t;

  // status from the sequencer to the stream side
  typedef struct packed {
    logic          idle;
    logic          res_valid;
    logic          selected;
    logic          bad_vertex;
    logic [TW-1:0] total;
    logic [VW-1:0] count;
  } seq_stat_t;

endpackage

>>> sv/kruskal_mst_edge_selector_unit.sv
// Kruskal edge selector: takes one weighted edge per transfer, in nondecreasing
// cost order, and reports whether it joins two components of a union-find
// forest, with the running saturating cost total, the selected-edge count, a
// tree-done flag and a bad-endpoint flag. One edge is handled at a time by a
// sequencer around a forest memory with one write port and one registered read
// port. Each item is evaluated, then each endpoint is walked to its root one
// parent link per step, and the nodes on that path are rewritten to point at the
// root; the union links the lower-rank root under the other and may raise a rank
// on a tie. Bad endpoints and edges after the tree is done skip the walk. The
// result appears on the output in the cycle the block is ready again, and a
// full output register holds the sequencer until the result drains.
// After reset, and on every sixteenth item marked first_edge, a clearing pass
// sweeps all min(MAX_VERTICES, 1024) entries of the forest memory before the block
// accepts or finishes an item. A finished result waits in an output register.
`timescale 1ns / 1ps
module kruskal_mst_edge_selector_unit import kmst_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration: vertex_count
  input  logic          cfg_we_i,
  input  logic [VW-1:0] cfg_wdata_i,
  // edge input
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [55:0]   s_axis_tdata_i,  // vertex_a[9:0], vertex_b[19:10], edge_cost[51:20]
  input  logic          s_axis_tuser_i,  // first_edge
  // result output
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [63:0]   m_axis_tdata_o   // selected[0], total_cost[48:1],
                                         // selected_count[58:49], tree_done[59],
                                         // bad_vertex[60]
);

  localparam int DEPTH = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;

  logic [VW-1:0] vc_q;
  logic          out_valid_q;
  logic [63:0]   out_data_q;
  logic          out_free, tree_done;
  seq_cmd_t      cmd;
  seq_stat_t     stat;
  mem_req_t      mem_req;
  node_t         mem_rdata;

  // vertex count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 10'd1023;
    end else if (cfg_we_i) begin
      vc_q <= cfg_wdata_i;
    end
  end

  // input transfer into the sequencer
  assign s_axis_tready_o = stat.idle;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign cmd = '{start:      s_axis_tvalid_i && stat.idle,
                 vertex_a:   s_axis_tdata_i[9:0],
                 vertex_b:   s_axis_tdata_i[19:10],
                 edge_cost:  s_axis_tdata_i[51:20],
                 first_edge: s_axis_tuser_i,
                 out_free:   out_free};

  kmst_seq #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vertex_count_i (vc_q),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .mem_o          (mem_req),
    .mem_rdata_i    (mem_rdata)
  );

  kmst_forest_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // tree done after this item
  assign tree_done = ({1'b0, stat.count} + 11'd1) >= {1'b0, vc_q};

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat.res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (stat.res_valid) begin
      out_data_q <= {3'b000, stat.bad_vertex, tree_done, stat.count, stat.total,
                     stat.selected};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

>>> sv/kmst_forest_ram.sv
// forest memory: one write port, one registered read port
`timescale 1ns / 1ps
module kmst_forest_ram import kmst_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output node_t    rdata_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  node_t mem_q [DEPTH];
  node_t rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[AW'(req_i.waddr)] <= req_i.wdata;
    end
    rdata_q <= mem_q[AW'(req_i.raddr)];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/kmst_seq.sv
// union-find sequencer: finds with path compression, union by rank, totals
`timescale 1ns / 1ps
`include "kruskal_mst_edge_selector_unit_defines.svh"
module kmst_seq import kmst_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [VW-1:0] vertex_count_i,
  input  seq_cmd_t      cmd_i,
  output seq_stat_t     stat_o,
  output mem_req_t      mem_o,
  input  node_t         mem_rdata_i
);

  localparam int DEPTH = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;
  localparam logic [VW-1:0] CLR_LAST = VW'(DEPTH - 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_EVAL   = 4'd2;
  localparam logic [3:0] S_FWALK  = 4'd3;
  localparam logic [3:0] S_COMP   = 4'd4;
  localparam logic [3:0] S_SWITCH = 4'd5;
  localparam logic [3:0] S_JOIN   = 4'd6;
  localparam logic [3:0] S_BUMP   = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [VW-1:0]      clr_q, clr_d;
  logic [3:0]         epoch_q, epoch_d;
  logic               pend_q, pend_d;
  logic [VW-1:0]      a_q, a_d, b_q, b_d;
  logic signed [31:0] cost_q, cost_d;
  logic               side_q, side_d;
  logic [VW-1:0]      cur_q, cur_d, root_q, root_d;
  logic [VW-1:0]      ra_q, ra_d, rb_q, rb_d;
  logic [3:0]         rka_q, rka_d, rkb_q, rkb_d;
  logic [TW-1:0]      total_q, total_d;
  logic [VW-1:0]      count_q, count_d;
  logic               sel_q, sel_d, bad_q, bad_d;

  logic               rd_ok;
  logic [VW-1:0]      rd_par, start_v;
  logic [3:0]         rd_rank;
  logic               bad_a, bad_b, done_now;
  logic [TW:0]        sum;
  logic [TW-1:0]      sat;
  logic               res_valid;
  mem_req_t           req;

  // stale epoch entries read as a fresh root
  assign rd_ok   = (mem_rdata_i.tag == epoch_q);
  assign rd_par  = rd_ok ? mem_rdata_i.parent : '0;
  assign rd_rank = rd_ok ? mem_rdata_i.rank : '0;
  assign start_v = side_q ? b_q : a_q;

  // endpoint range and tree completion checks
  assign bad_a = (a_q == '0) || (a_q > vertex_count_i) || !(32'(a_q) < MAX_VERTICES);
  assign bad_b = (b_q == '0) || (b_q > vertex_count_i) || !(32'(b_q) < MAX_VERTICES);
  assign done_now = ({1'b0, count_q} + 11'd1) >= {1'b0, vertex_count_i};

  // saturating total update
  assign sum = {total_q[TW-1], total_q} + {{(TW-31){cost_q[31]}}, cost_q};
  assign sat = (sum[TW] != sum[TW-1]) ? (sum[TW] ? TOTAL_MIN : TOTAL_MAX) : sum[TW-1:0];

  // sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    epoch_d   = epoch_q;
    pend_d    = pend_q;
    a_d       = a_q;
    b_d       = b_q;
    cost_d    = cost_q;
    side_d    = side_q;
    cur_d     = cur_q;
    root_d    = root_q;
    ra_d      = ra_q;
    rb_d      = rb_q;
    rka_d     = rka_q;
    rkb_d     = rkb_q;
    total_d   = total_q;
    count_d   = count_q;
    sel_d     = sel_q;
    bad_d     = bad_q;
    res_valid = 1'b0;
    req       = '0;
    case (state_q)
      S_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = clr_q;
        req.wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == CLR_LAST) begin
          clr_d   = '0;
          pend_d  = 1'b0;
          state_d = pend_q ? S_EVAL : S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_i.start) begin
          a_d     = cmd_i.vertex_a;
          b_d     = cmd_i.vertex_b;
          cost_d  = cmd_i.edge_cost;
          state_d = S_EVAL;
          if (cmd_i.first_edge) begin
            total_d = '0;
            count_d = '0;
            if (epoch_q == EPOCH_MAX) begin
              epoch_d = '0;
              pend_d  = 1'b1;
              clr_d   = '0;
              state_d = S_CLEAR;
            end else begin
              epoch_d = epoch_q + 1'b1;
            end
          end
        end
      end
      S_EVAL: begin
        bad_d = bad_a || bad_b;
        sel_d = 1'b0;
        if (bad_a || bad_b || done_now) begin
          state_d = S_FIN;
        end else begin
          side_d    = 1'b0;
          cur_d     = a_q;
          req.raddr = a_q;
          state_d   = S_FWALK;
        end
      end
      S_FWALK: begin
        if (rd_par == '0) begin
          root_d = cur_q;
          if (side_q) begin
            rb_d  = cur_q;
            rkb_d = rd_rank;
          end else begin
            ra_d  = cur_q;
            rka_d = rd_rank;
          end
          if (start_v == cur_q) begin
            state_d = S_SWITCH;
          end else begin
            cur_d     = start_v;
            req.raddr = start_v;
            state_d   = S_COMP;
          end
        end else begin
          cur_d     = rd_par;
          req.raddr = rd_par;
        end
      end
      S_COMP: begin
        // point this node straight at the root
        req.we    = 1'b1;
        req.waddr = cur_q;
        req.wdata = '{tag: epoch_q, rank: 4'd0, parent: root_q};
        if (rd_par == root_q) begin
          state_d = S_SWITCH;
        end else begin
          cur_d     = rd_par;
          req.raddr = rd_par;
        end
      end
      S_SWITCH: begin
        if (side_q) begin
          state_d = S_JOIN;
        end else begin
          side_d    = 1'b1;
          cur_d     = b_q;
          req.raddr = b_q;
          state_d   = S_FWALK;
        end
      end
      S_JOIN: begin
        state_d = S_FIN;
        if (ra_q == rb_q) begin
          sel_d = 1'b0;
        end else begin
          sel_d   = 1'b1;
          total_d = sat;
          count_d = count_q + 1'b1;
          req.we  = 1'b1;
          if (rka_q > rkb_q) begin
            req.waddr = rb_q;
            req.wdata = '{tag: epoch_q, rank: rkb_q, parent: ra_q};
          end else begin
            req.waddr = ra_q;
            req.wdata = '{tag: epoch_q, rank: rka_q, parent: rb_q};
            if ((rka_q == rkb_q) && (rkb_q != RANK_MAX)) begin
              state_d = S_BUMP;
            end
          end
        end
      end
      S_BUMP: begin
        req.we    = 1'b1;
        req.waddr = rb_q;
        req.wdata = '{tag: epoch_q, rank: rkb_q + 4'd1, parent: '0};
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (cmd_i.out_free) begin
          res_valid = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      epoch_q <= '0;
      pend_q  <= 1'b0;
      total_q <= '0;
      count_q <= '0;
      sel_q   <= 1'b0;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      epoch_q <= epoch_d;
      pend_q  <= pend_d;
      total_q <= total_d;
      count_q <= count_d;
      sel_q   <= sel_d;
      bad_q   <= bad_d;
    end
  end

  // item payload and walk registers
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    cost_q <= cost_d;
    side_q <= side_d;
    cur_q  <= cur_d;
    root_q <= root_d;
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    rka_q  <= rka_d;
    rkb_q  <= rkb_d;
  end

  assign mem_o = req;

  assign stat_o = '{idle:       (state_q == S_IDLE),
                    res_valid:  res_valid,
                    selected:   sel_q,
                    bad_vertex: bad_q,
                    total:      total_q,
                    count:      count_q};

  // checks
  `KMST_ASSERT_NOW(a_comp_not_root, state_q == S_COMP, cur_q != root_q, "compression hit root")
  `KMST_ASSERT_NEXT(a_fin_to_idle, res_valid, state_q == S_IDLE, "result not followed by idle")
  `KMST_ASSERT_NOW(a_count_range, 1'b1, count_q != 10'h3FF, "selected count out of range")
  `KMST_ASSERT_NEXT(a_join_selects, (state_q == S_JOIN) && (ra_q != rb_q), sel_q,
                    "distinct roots not selected")
  `KMST_ASSERT_NOW(a_clear_epoch, state_q == S_CLEAR, epoch_q == 4'd0, "clear pass off epoch 0")

endmodule
